>>> design/bounded_unordered_set_top_macros.svh
// assertion macros used by the top-level design file
`ifndef BOUNDED_UNORDERED_SET_TOP_MACROS_SVH
`define BOUNDED_UNORDERED_SET_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BSET_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bset assertion failed");

// next-cycle implication
`define BSET_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bset assertion failed");

`else

`define BSET_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BSET_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/bset_pkg.sv
package bset_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // operations
    localparam logic [FUNC_W-1:0] F_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] F_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] F_LOOKUP = 2'd2;
    localparam logic [FUNC_W-1:0] F_CLEAR  = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;

    // microprogram addresses
    localparam int UPC_W = 5;
    localparam logic [UPC_W-1:0] P_IDLE    = 5'd0;
    localparam logic [UPC_W-1:0] P_DISP    = 5'd1;
    localparam logic [UPC_W-1:0] P_DISP2   = 5'd2;
    localparam logic [UPC_W-1:0] P_DISP3   = 5'd3;
    localparam logic [UPC_W-1:0] P_INS     = 5'd4;
    localparam logic [UPC_W-1:0] P_REM     = 5'd5;
    localparam logic [UPC_W-1:0] P_SCAN    = 5'd6;
    localparam logic [UPC_W-1:0] P_RES     = 5'd7;
    localparam logic [UPC_W-1:0] P_FND     = 5'd8;
    localparam logic [UPC_W-1:0] P_FND2    = 5'd9;
    localparam logic [UPC_W-1:0] P_MISS    = 5'd10;
    localparam logic [UPC_W-1:0] P_RDLAST  = 5'd11;
    localparam logic [UPC_W-1:0] P_MOVE    = 5'd12;
    localparam logic [UPC_W-1:0] P_APPEND  = 5'd13;
    localparam logic [UPC_W-1:0] P_CLR     = 5'd14;
    localparam logic [UPC_W-1:0] P_E_FULL  = 5'd15;
    localparam logic [UPC_W-1:0] P_E_EMPTY = 5'd16;
    localparam logic [UPC_W-1:0] P_E_PRES  = 5'd17;
    localparam logic [UPC_W-1:0] P_E_OK    = 5'd18;
    localparam logic [UPC_W-1:0] P_E_MISS  = 5'd19;
    localparam logic [UPC_W-1:0] P_EMIT    = 5'd20;

    // jump conditions
    localparam int COND_W = 4;
    localparam logic [COND_W-1:0] C_ALWAYS = 4'd0;
    localparam logic [COND_W-1:0] C_IN     = 4'd1;
    localparam logic [COND_W-1:0] C_INS    = 4'd2;
    localparam logic [COND_W-1:0] C_REM    = 4'd3;
    localparam logic [COND_W-1:0] C_CLR    = 4'd4;
    localparam logic [COND_W-1:0] C_FULL   = 4'd5;
    localparam logic [COND_W-1:0] C_EMPTY  = 4'd6;
    localparam logic [COND_W-1:0] C_SEND   = 4'd7;
    localparam logic [COND_W-1:0] C_FOUND  = 4'd8;
    localparam logic [COND_W-1:0] C_OFREE  = 4'd9;

    // datapath actions
    localparam int ACT_W = 3;
    localparam logic [ACT_W-1:0] A_NONE   = 3'd0;
    localparam logic [ACT_W-1:0] A_LOAD   = 3'd1;
    localparam logic [ACT_W-1:0] A_SCAN   = 3'd2;
    localparam logic [ACT_W-1:0] A_RDLAST = 3'd3;
    localparam logic [ACT_W-1:0] A_MOVE   = 3'd4;
    localparam logic [ACT_W-1:0] A_APPEND = 3'd5;
    localparam logic [ACT_W-1:0] A_CLEAR  = 3'd6;
    localparam logic [ACT_W-1:0] A_EMIT   = 3'd7;

    typedef struct packed {
        logic [COND_W-1:0]   cond;
        logic [UPC_W-1:0]    jump;
        logic [UPC_W-1:0]    next;
        logic [ACT_W-1:0]    act;
        logic                set_st;
        logic [STATUS_W-1:0] st;
    } t_uword;

    function automatic t_uword mk(
        input logic [COND_W-1:0]   cond,
        input logic [UPC_W-1:0]    jump,
        input logic [UPC_W-1:0]    next,
        input logic [ACT_W-1:0]    act,
        input logic                set_st,
        input logic [STATUS_W-1:0] st
    );
        t_uword w;
        w.cond   = cond;
        w.jump   = jump;
        w.next   = next;
        w.act    = act;
        w.set_st = set_st;
        w.st     = st;
        return w;
    endfunction

    // control store
    function automatic t_uword ucode(input logic [UPC_W-1:0] a);
        t_uword w;
        unique case (a)
            P_IDLE:    w = mk(C_IN,     P_DISP,   P_IDLE,    A_LOAD,   1'b0, ST_DONE);
            P_DISP:    w = mk(C_INS,    P_INS,    P_DISP2,   A_NONE,   1'b0, ST_DONE);
            P_DISP2:   w = mk(C_REM,    P_REM,    P_DISP3,   A_NONE,   1'b0, ST_DONE);
            P_DISP3:   w = mk(C_CLR,    P_CLR,    P_SCAN,    A_NONE,   1'b0, ST_DONE);
            P_INS:     w = mk(C_FULL,   P_E_FULL, P_SCAN,    A_NONE,   1'b0, ST_DONE);
            P_REM:     w = mk(C_EMPTY,  P_E_EMPTY, P_SCAN,   A_NONE,   1'b0, ST_DONE);
            P_SCAN:    w = mk(C_SEND,   P_RES,    P_SCAN,    A_SCAN,   1'b0, ST_DONE);
            P_RES:     w = mk(C_FOUND,  P_FND,    P_MISS,    A_NONE,   1'b0, ST_DONE);
            P_FND:     w = mk(C_INS,    P_E_PRES, P_FND2,    A_NONE,   1'b0, ST_DONE);
            P_FND2:    w = mk(C_REM,    P_RDLAST, P_E_OK,    A_NONE,   1'b0, ST_DONE);
            P_MISS:    w = mk(C_INS,    P_APPEND, P_E_MISS,  A_NONE,   1'b0, ST_DONE);
            P_RDLAST:  w = mk(C_ALWAYS, P_MOVE,   P_MOVE,    A_RDLAST, 1'b0, ST_DONE);
            P_MOVE:    w = mk(C_ALWAYS, P_EMIT,   P_EMIT,    A_MOVE,   1'b1, ST_DONE);
            P_APPEND:  w = mk(C_ALWAYS, P_EMIT,   P_EMIT,    A_APPEND, 1'b1, ST_DONE);
            P_CLR:     w = mk(C_ALWAYS, P_EMIT,   P_EMIT,    A_CLEAR,  1'b1, ST_DONE);
            P_E_FULL:  w = mk(C_ALWAYS, P_EMIT,   P_EMIT,    A_NONE,   1'b1, ST_FULL);
            P_E_EMPTY: w = mk(C_ALWAYS, P_EMIT,   P_EMIT,    A_NONE,   1'b1, ST_EMPTY);
            P_E_PRES:  w = mk(C_ALWAYS, P_EMIT,   P_EMIT,    A_NONE,   1'b1, ST_PRESENT);
            P_E_OK:    w = mk(C_ALWAYS, P_EMIT,   P_EMIT,    A_NONE,   1'b1, ST_DONE);
            P_E_MISS:  w = mk(C_ALWAYS, P_EMIT,   P_EMIT,    A_NONE,   1'b1, ST_MISSING);
            P_EMIT:    w = mk(C_OFREE,  P_IDLE,   P_EMIT,    A_EMIT,   1'b0, ST_DONE);
            default:   w = mk(C_ALWAYS, P_IDLE,   P_IDLE,    A_NONE,   1'b0, ST_DONE);
        endcase
        return w;
    endfunction

endpackage

>>> design/bounded_unordered_set_top.sv
// bounded unordered set of byte keys: holds up to CAPACITY distinct keys in a
// small ram plus a count. each input word carries an operation (insert if new,
// remove, lookup, clear) and a key, and gives exactly one result word with a
// status, the count after the operation and full/empty flags. control is a
// microprogram in a constant control store: one control word per step, a
// program counter and conditional jumps drive a datapath of one ram read
// port, one key comparator and the count register. one word is worked on at a
// time; the search compares one stored entry per cycle, and the next word can
// be taken the cycle after a result is registered. the result sits in an output
// register, so a new word is accepted while the previous result still waits
// downstream. the ram needs no clearing after reset since only entries below
// the count are read.
`include "bounded_unordered_set_top_macros.svh"

module bounded_unordered_set_top #(
    parameter int CAPACITY = bset_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input word
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bset_pkg::FUNC_W-1:0]   i_func,
    input  logic [bset_pkg::KEY_W-1:0]    i_key,
    // result word
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bset_pkg::STATUS_W-1:0] o_status,
    output logic [bset_pkg::COUNT_W-1:0]  o_count,
    output logic                          o_full_res,
    output logic                          o_empty_res
);

    import bset_pkg::*;

    // count holds 0..CAPACITY, address covers 0..CAPACITY-1
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW_EX = (CW > COUNT_W) ? CW : COUNT_W;

    // sequencer
    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           w;
    logic             cond_true;

    // datapath
    logic [FUNC_W-1:0]   r_op;
    logic [KEY_W-1:0]    r_key;
    logic [CW-1:0]       r_held;
    logic [CW-1:0]       n_held;
    logic [CW-1:0]       r_idx;
    logic                r_pend;
    logic                r_found;
    logic [AW-1:0]       r_slot;
    logic [STATUS_W-1:0] r_status;

    // output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [COUNT_W-1:0]  r_o_count;
    logic                r_o_full;
    logic                r_o_empty;

    // ram port
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [KEY_W-1:0]  ram_rdata;

    logic              in_acc;
    logic              out_free;
    logic              hit;
    logic              scan_end;
    logic [CW-1:0]     idx_prev;
    logic [CW-1:0]     held_dec;
    logic [CW_EX-1:0]  held_ex;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // the ram returns the entry addressed in the previous scan cycle
    assign hit      = r_pend && (ram_rdata == r_key);
    assign scan_end = hit || (r_idx == r_held);
    assign idx_prev = r_idx - CW'(1);
    assign held_dec = r_held - CW'(1);
    assign held_ex  = CW_EX'(r_held);

    assign w = ucode(r_upc);

    // jump condition select
    always_comb begin
        unique case (w.cond)
            C_ALWAYS: cond_true = 1'b1;
            C_IN:     cond_true = i_in_valid;
            C_INS:    cond_true = (r_op == F_INSERT);
            C_REM:    cond_true = (r_op == F_REMOVE);
            C_CLR:    cond_true = (r_op == F_CLEAR);
            C_FULL:   cond_true = (r_held == CW'(CAPACITY));
            C_EMPTY:  cond_true = (r_held == '0);
            C_SEND:   cond_true = scan_end;
            C_FOUND:  cond_true = r_found;
            C_OFREE:  cond_true = out_free;
            default:  cond_true = 1'b0;
        endcase
    end

    assign n_upc      = cond_true ? w.jump : w.next;
    assign o_in_ready = (r_upc == P_IDLE);

    // ram addressing: scan reads at the index, remove reads the last entry
    always_comb begin
        ram_raddr = r_idx[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = ram_rdata;
        n_held    = r_held;
        case (w.act)
            A_RDLAST: begin
                ram_raddr = held_dec[AW-1:0];
            end
            A_MOVE: begin
                // last entry fills the hole
                ram_we = 1'b1;
                n_held = held_dec;
            end
            A_APPEND: begin
                ram_we    = 1'b1;
                ram_waddr = r_held[AW-1:0];
                ram_wdata = r_key;
                n_held    = r_held + CW'(1);
            end
            A_CLEAR: begin
                n_held = '0;
            end
            default: begin
            end
        endcase
    end

    bset_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= P_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_upc  <= n_upc;
            r_held <= n_held;
            if (w.act == A_LOAD) begin
                r_pend <= 1'b0;
            end else if (w.act == A_SCAN && !scan_end) begin
                r_pend <= 1'b1;
            end
            if (w.act == A_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w.act == A_LOAD && in_acc) begin
            r_op  <= i_func;
            r_key <= i_key;
        end
        if (w.act == A_LOAD) begin
            r_idx <= '0;
        end else if (w.act == A_SCAN) begin
            r_found <= hit;
            r_slot  <= idx_prev[AW-1:0];
            if (!scan_end) begin
                r_idx <= r_idx + CW'(1);
            end
        end
        if (w.set_st) begin
            r_status <= w.st;
        end
        if (w.act == A_EMIT && out_free) begin
            r_o_status <= r_status;
            r_o_count  <= held_ex[COUNT_W-1:0];
            r_o_full   <= (r_held == CW'(CAPACITY));
            r_o_empty  <= (r_held == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_count     = r_o_count;
    assign o_full_res  = r_o_full;
    assign o_empty_res = r_o_empty;

    // count never passes capacity
    `BSET_ASSERT_IMP(a_held_bound, i_clk, i_rst_n, 1'b1, r_held <= CW'(CAPACITY))
    // an accepted word always starts at dispatch
    `BSET_ASSERT_NXT(a_accept_disp, i_clk, i_rst_n, in_acc, r_upc == P_DISP)
    // a result appears only from the emit step
    `BSET_ASSERT_NXT(a_emit_only, i_clk, i_rst_n, !o_out_valid && r_upc != P_EMIT, !o_out_valid)
    // the count moves by at most one except on clear
    `BSET_ASSERT_NXT(a_held_step, i_clk, i_rst_n, w.act != A_CLEAR,
        r_held == $past(r_held) || r_held == $past(r_held) + CW'(1) || r_held == $past(held_dec))

endmodule

>>> design/bset_ram.sv
module bset_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bset_pkg::*;

    localparam int CAPACITY      = CAPACITY_DEF;
    localparam int WORDS_PER_RUN = 550;   // random words in each idling phase
    localparam int DRAIN_CYCLES  = 40;    // wait after the last result is taken
    localparam int QUIET_LIMIT   = 2000;  // cycles without any handshake
    localparam int POOL_SIZE     = 24;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #2 i_clk = ~i_clk;

    // dut ports, all known from time zero
    logic                i_in_valid  = 1'b0;
    logic                i_out_ready = 1'b0;
    logic [FUNC_W-1:0]   i_func      = F_LOOKUP;
    logic [KEY_W-1:0]    i_key       = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_count;
    logic                o_full_res;
    logic                o_empty_res;

    bounded_unordered_set_top #(
        .CAPACITY    (CAPACITY)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_full_res  (o_full_res),
        .o_empty_res (o_empty_res)
    );

    // one result word as the set reports it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                full;
        logic                empty;
    } t_set_result;

    // directed row: when typed is set the result is given right here,
    // otherwise it comes from the set model below
    typedef struct packed {
        logic [FUNC_W-1:0]   op;
        logic [KEY_W-1:0]    key;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_script_row;

    localparam int SCRIPT_LEN = 27;

    t_script_row script [SCRIPT_LEN] = '{
        // empty set: lookup misses, remove reports empty, clear is harmless
        '{F_LOOKUP, 8'h00, 1'b1, ST_MISSING, 5'd0},
        '{F_REMOVE, 8'hFF, 1'b1, ST_EMPTY,   5'd0},
        '{F_CLEAR,  8'h00, 1'b1, ST_DONE,    5'd0},
        // key extremes, then a repeated key
        '{F_INSERT, 8'h00, 1'b1, ST_DONE,    5'd1},
        '{F_INSERT, 8'hFF, 1'b1, ST_DONE,    5'd2},
        '{F_INSERT, 8'h00, 1'b1, ST_PRESENT, 5'd2},
        // fill up to capacity with walking bits and stripes
        '{F_INSERT, 8'h01, 1'b0, ST_DONE,    5'd0},
        '{F_INSERT, 8'h02, 1'b0, ST_DONE,    5'd0},
        '{F_INSERT, 8'h04, 1'b0, ST_DONE,    5'd0},
        '{F_INSERT, 8'h08, 1'b0, ST_DONE,    5'd0},
        '{F_INSERT, 8'h10, 1'b0, ST_DONE,    5'd0},
        '{F_INSERT, 8'h20, 1'b0, ST_DONE,    5'd0},
        '{F_INSERT, 8'h40, 1'b0, ST_DONE,    5'd0},
        '{F_INSERT, 8'h80, 1'b0, ST_DONE,    5'd0},
        '{F_INSERT, 8'hAA, 1'b0, ST_DONE,    5'd0},
        '{F_INSERT, 8'h55, 1'b0, ST_DONE,    5'd0},
        '{F_INSERT, 8'h0F, 1'b0, ST_DONE,    5'd0},
        '{F_INSERT, 8'hF0, 1'b0, ST_DONE,    5'd0},
        '{F_INSERT, 8'h33, 1'b0, ST_DONE,    5'd0},
        '{F_INSERT, 8'hCC, 1'b0, ST_DONE,    5'd0},
        // full set: fullness wins over presence
        '{F_INSERT, 8'hFF, 1'b1, ST_FULL,    5'd16},
        '{F_INSERT, 8'h77, 1'b1, ST_FULL,    5'd16},
        '{F_LOOKUP, 8'h80, 1'b0, ST_DONE,    5'd0},
        // removing the first slot pulls the last key into the hole
        '{F_REMOVE, 8'h00, 1'b1, ST_DONE,    5'd15},
        '{F_REMOVE, 8'h00, 1'b1, ST_MISSING, 5'd15},
        '{F_LOOKUP, 8'hCC, 1'b0, ST_DONE,    5'd0},
        '{F_CLEAR,  8'hFF, 1'b1, ST_DONE,    5'd0}
    };

    // software copy of the set
    logic [KEY_W-1:0] set_keys [CAPACITY];
    int unsigned      set_size = 0;

    t_set_result      pending_results [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int sender_gap_pct = 0;
    int sink_stall_pct = 0;
    int mismatches     = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int full_results   = 0;
    int status_tally [5] = '{0, 0, 0, 0, 0};
    int quiet_cycles   = 0;

    // slot of a held key, or -1; only slots below the count are looked at
    function automatic int find_key(input logic [KEY_W-1:0] k);
        int i;
        for (i = 0; i < set_size; i++) begin
            if (set_keys[i] == k) return i;
        end
        return -1;
    endfunction

    // applies one operation to the software set and returns its result word
    function automatic t_set_result apply_set_op(input logic [FUNC_W-1:0] op,
                                                 input logic [KEY_W-1:0] k);
        t_set_result res;
        int          slot;
        res.status = ST_DONE;
        slot = find_key(k);
        case (op)
            F_INSERT: begin
                // fullness is checked before presence
                if (set_size >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (slot >= 0) begin
                    res.status = ST_PRESENT;
                end else begin
                    set_keys[set_size] = k;
                    set_size++;
                end
            end
            F_REMOVE: begin
                if (set_size == 0) begin
                    res.status = ST_EMPTY;
                end else if (slot < 0) begin
                    res.status = ST_MISSING;
                end else begin
                    // last held key fills the hole
                    set_keys[slot] = set_keys[set_size - 1];
                    set_size--;
                end
            end
            F_LOOKUP: begin
                res.status = (slot >= 0) ? ST_DONE : ST_MISSING;
            end
            default: begin
                set_size = 0;
            end
        endcase
        res.count = set_size[COUNT_W-1:0];
        res.full  = (set_size == CAPACITY);
        res.empty = (set_size == 0);
        return res;
    endfunction

    // key choice: mostly keys likely to hit, some fully random
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25 && set_size != 0) return set_keys[$urandom_range(0, set_size - 1)];
        if (r < 80) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return KEY_W'($urandom_range(0, 255));
    endfunction

    // offers one word, holds it until taken, then queues what it should give
    task automatic send_word(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic typed, input t_set_result typed_res);
        t_set_result predicted;
        while ($urandom_range(0, 99) < sender_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= op;
        i_key      <= k;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_set_op(op, k);
        pending_results.push_back(typed ? typed_res : predicted);
        words_sent++;
    endtask

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
            mismatches++;
        end
    endtask

    // result side: random back-pressure, compare each taken word in order
    always @(posedge i_clk) begin : result_sink
        t_set_result due;
        i_out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got status %0d count %0d",
                         $time, o_status, o_count);
                mismatches++;
            end else begin
                due = pending_results.pop_front();
                check_field("status", due.status, o_status);
                check_field("count", due.count, o_count);
                check_field("full", due.full, o_full_res);
                check_field("empty", due.empty, o_empty_res);
                if (o_full_res) full_results++;
                if (o_status <= ST_MISSING) status_tally[o_status]++;
            end
        end
    end

    // counts cycles in which neither side moves a word
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("%0t: no handshake for %0d cycles, %0d results still due",
                 $time, QUIET_LIMIT, pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        t_set_result      typed_res;
        logic [FUNC_W-1:0] op;
        int               r;
        int               ins_pct;
        int               rem_pct;
        int               phase;
        int               n;

        foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom_range(0, 255));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        sender_gap_pct = 7;
        sink_stall_pct = 81;

        // directed walk through the corner cases
        foreach (script[i]) begin
            typed_res.status = script[i].status;
            typed_res.count  = script[i].count;
            typed_res.full   = (script[i].count == CAPACITY);
            typed_res.empty  = (script[i].count == 0);
            send_word(script[i].op, script[i].key, script[i].typed, typed_res);
        end

        // random words in three idling phases: sender-heavy, receiver-heavy, none
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_gap_pct = 7;
                    sink_stall_pct = 81;
                end
                1: begin
                    sender_gap_pct = 81;
                    sink_stall_pct = 7;
                end
                default: begin
                    sender_gap_pct = 0;
                    sink_stall_pct = 0;
                end
            endcase
            for (n = 0; n < WORDS_PER_RUN; n++) begin
                // alternate growing and shrinking stretches so the set fills and drains
                if ((n / 48) % 2 == 0) begin
                    ins_pct = 62;
                    rem_pct = 17;
                end else begin
                    ins_pct = 25;
                    rem_pct = 45;
                end
                r = $urandom_range(0, 99);
                if (r < 1)                           op = F_CLEAR;
                else if (r < 1 + ins_pct)            op = F_INSERT;
                else if (r < 1 + ins_pct + rem_pct)  op = F_REMOVE;
                else                                 op = F_LOOKUP;
                send_word(op, pick_key(), 1'b0, typed_res);
            end
        end
        i_in_valid <= 1'b0;

        // drain outstanding results, then give the block time to misbehave
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d words, checked %0d results, %0d of them with the set full",
                 words_sent, results_seen, full_results);
        $display("status spread: done %0d, full %0d, present %0d, empty %0d, missing %0d",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 status_tally[4]);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/bset_pkg.sv
design/bset_ram.sv
design/bounded_unordered_set_top.sv
test/testbench.sv
